>>> src/proximity_collision_qualifier_defines.svh
// Assertion macros for the proximity collision qualifier.
// Clocked on clk, disabled while rst_n is low; used by the top level only.
`ifndef PROXIMITY_COLLISION_QUALIFIER_DEFINES_SVH
`define PROXIMITY_COLLISION_QUALIFIER_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication
`define PCQ_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define PCQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define PCQ_ASSERT_NOW(label, ante, cons, msg)
`define PCQ_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

>>> src/pcq_pkg.sv
// Shared types and constants for the proximity collision qualifier.
// No dependencies; used by pcq_lane, pcq_merge and the top level.
`timescale 1ns / 1ps

package pcq_pkg;

    localparam int SAMPLE_BITS    = 10;
    localparam int NUM_CHANNELS   = 6;
    localparam int CNT_BITS       = 8;
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = SAMPLE_BITS;

    typedef logic [SAMPLE_BITS-1:0]    sample_t;
    typedef logic [CNT_BITS-1:0]       cnt_t;
    typedef logic [NUM_CHANNELS-1:0]   flags_t;
    typedef logic [CFG_INDEX_BITS-1:0] cfg_index_t;
    typedef logic [CFG_DATA_BITS-1:0]  cfg_data_t;

    // Limits reset to 1023, cut to the sample width
    localparam sample_t LIMIT_RESET   = sample_t'(1023);
    localparam cnt_t    CONFIRM_RESET = cnt_t'(2);
    localparam cnt_t    CNT_MAX       = '1;

    // Register indexes: 0..5 are channel limits, then the confirm count
    localparam cfg_index_t REG_CONFIRM_COUNT = cfg_index_t'(NUM_CHANNELS);

    // Channel order in qualified_flags
    localparam int CH_REAR_INT     = 0;
    localparam int CH_REAR_INT_FAR = 1;
    localparam int CH_REAR_HOOP    = 2;
    localparam int CH_LEFT_HOOP    = 3;
    localparam int CH_RIGHT_HOOP   = 4;
    localparam int CH_FRONT        = 5;

    typedef struct packed {
        sample_t rear_internal_sample;
        sample_t rear_hoop_sample;
        sample_t left_hoop_sample;
        sample_t right_hoop_sample;
        sample_t front_sample;
        logic    hoops_down;
    } scan_t;

    typedef struct packed {
        logic   collision_rear;
        logic   collision_rear_far;
        logic   collision_front;
        logic   collision_left;
        logic   collision_right;
        flags_t qualified_flags;
    } result_t;

    // Per-scan control broadcast to every lane
    typedef struct packed {
        logic fire;
        cnt_t confirm;
    } lane_ctrl_t;

endpackage

>>> src/pcq_lane.sv
// One debounce lane: threshold compare, saturating hit counter and flag.
// Depends on pcq_pkg.
`timescale 1ns / 1ps

module pcq_lane
(
    input  logic                clk,
    input  logic                rst_n,
    input  pcq_pkg::lane_ctrl_t ctrl,
    input  pcq_pkg::sample_t    sample,
    input  pcq_pkg::sample_t    limit,
    output logic                flag_next
);

    pcq_pkg::cnt_t cnt_reg;
    pcq_pkg::cnt_t cnt_next;
    logic          flag_reg;
    logic          hit;

    // Count strictly-above samples, saturate at top, clear on a miss
    always_comb
    begin
        hit = (sample > limit);
        if (hit)
        begin
            if (cnt_reg == pcq_pkg::CNT_MAX)
            begin
                cnt_next = cnt_reg;
            end
            else
            begin
                cnt_next = cnt_reg + pcq_pkg::cnt_t'(1);
            end
            flag_next = flag_reg | (cnt_next >= ctrl.confirm);
        end
        else
        begin
            cnt_next  = '0;
            flag_next = 1'b0;
        end
    end

    // Lane state advances only on a scan transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            flag_reg <= 1'b0;
        end
        else if (ctrl.fire)
        begin
            cnt_reg  <= cnt_next;
            flag_reg <= flag_next;
        end
    end

endmodule

>>> src/pcq_merge.sv
// Merge stage: maps the six lane flags to collision outputs by mode and
// holds the result in the output register. Depends on pcq_pkg.
`timescale 1ns / 1ps

module pcq_merge
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  pcq_pkg::flags_t  flags,
    input  logic             hoops_down,
    input  logic             result_ready,
    output logic             result_valid,
    output pcq_pkg::result_t result
);

    pcq_pkg::result_t result_reg;
    pcq_pkg::result_t result_next;
    logic             valid_reg;
    logic             valid_next;

    // Output selection by hoop mode
    always_comb
    begin
        result_next.qualified_flags = flags;
        result_next.collision_front = flags[pcq_pkg::CH_FRONT];
        if (hoops_down)
        begin
            result_next.collision_rear     = flags[pcq_pkg::CH_REAR_HOOP];
            result_next.collision_rear_far = 1'b0;
            result_next.collision_left     = flags[pcq_pkg::CH_LEFT_HOOP];
            result_next.collision_right    = flags[pcq_pkg::CH_RIGHT_HOOP];
        end
        else
        begin
            result_next.collision_rear     = flags[pcq_pkg::CH_REAR_INT];
            result_next.collision_rear_far = flags[pcq_pkg::CH_REAR_INT_FAR];
            result_next.collision_left     = 1'b0;
            result_next.collision_right    = 1'b0;
        end
    end

    // Valid: set on load, drop when the held result transfers
    always_comb
    begin
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload register, no reset needed
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= result_next;
        end
    end

    assign result_valid = valid_reg;
    assign result       = result_reg;

endmodule

>>> src/proximity_collision_qualifier.sv
// Proximity collision qualifier top level: config registers, six debounce
// lanes and the merge/output stage. Depends on pcq_pkg, pcq_lane, pcq_merge
// and proximity_collision_qualifier_defines.svh.
//
// Usage:
//   scan channel (scan_valid/scan_ready/scan) carries five distance samples
//   and the hoops_down mode bit. Each scan yields exactly one result on the
//   result channel (result_valid/result_ready/result).
//   Latency: the result is valid the cycle after the scan transfer.
//   Throughput: one scan per cycle; all six channel lanes update in the
//   cycle of the transfer, and the single output register sets the pace.
//   scan_ready is high whenever the output register is empty or its result
//   is taken in the same cycle; while the receiver stalls, one result is
//   held and the next scan waits.
//   cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data) is always ready;
//   indexes 0..5 write channel limits, 6 writes the confirm count (low 8
//   bits), 7 is ignored. Write only while no scan is in flight.
//   Reset: limits go to all ones, confirm count to 2, counters and flags
//   clear, no result is pending.
`timescale 1ns / 1ps
`include "proximity_collision_qualifier_defines.svh"

module proximity_collision_qualifier
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 scan_valid,
    output logic                 scan_ready,
    input  pcq_pkg::scan_t       scan,
    output logic                 result_valid,
    input  logic                 result_ready,
    output pcq_pkg::result_t     result,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  pcq_pkg::cfg_index_t  cfg_index,
    input  pcq_pkg::cfg_data_t   cfg_data
);

    pcq_pkg::sample_t    limit_reg [pcq_pkg::NUM_CHANNELS];
    pcq_pkg::cnt_t       confirm_reg;
    pcq_pkg::sample_t    lane_sample [pcq_pkg::NUM_CHANNELS];
    pcq_pkg::flags_t     flags_next;
    pcq_pkg::lane_ctrl_t lane_ctrl;
    logic                scan_fire;
    logic                cfg_fire;

    assign cfg_ready  = 1'b1;
    assign cfg_fire   = cfg_valid & cfg_ready;
    assign scan_ready = ~result_valid | result_ready;
    assign scan_fire  = scan_valid & scan_ready;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < pcq_pkg::NUM_CHANNELS; i++)
            begin
                limit_reg[i] <= pcq_pkg::LIMIT_RESET;
            end
            confirm_reg <= pcq_pkg::CONFIRM_RESET;
        end
        else if (cfg_fire)
        begin
            for (int i = 0; i < pcq_pkg::NUM_CHANNELS; i++)
            begin
                if (cfg_index == pcq_pkg::cfg_index_t'(i))
                begin
                    limit_reg[i] <= cfg_data[pcq_pkg::SAMPLE_BITS-1:0];
                end
            end
            if (cfg_index == pcq_pkg::REG_CONFIRM_COUNT)
            begin
                confirm_reg <= cfg_data[pcq_pkg::CNT_BITS-1:0];
            end
        end
    end

    // Both rear internal channels watch the same sensor
    assign lane_sample[pcq_pkg::CH_REAR_INT]     = scan.rear_internal_sample;
    assign lane_sample[pcq_pkg::CH_REAR_INT_FAR] = scan.rear_internal_sample;
    assign lane_sample[pcq_pkg::CH_REAR_HOOP]    = scan.rear_hoop_sample;
    assign lane_sample[pcq_pkg::CH_LEFT_HOOP]    = scan.left_hoop_sample;
    assign lane_sample[pcq_pkg::CH_RIGHT_HOOP]   = scan.right_hoop_sample;
    assign lane_sample[pcq_pkg::CH_FRONT]        = scan.front_sample;

    assign lane_ctrl.fire    = scan_fire;
    assign lane_ctrl.confirm = confirm_reg;

    // Channel lanes
    for (genvar c = 0; c < pcq_pkg::NUM_CHANNELS; c++)
    begin : g_lane
        pcq_lane u_lane
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (lane_ctrl),
            .sample    (lane_sample[c]),
            .limit     (limit_reg[c]),
            .flag_next (flags_next[c])
        );
    end

    // Merge and output register
    pcq_merge u_merge
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (scan_fire),
        .flags        (flags_next),
        .hoops_down   (scan.hoops_down),
        .result_ready (result_ready),
        .result_valid (result_valid),
        .result       (result)
    );

    // Checks
    `PCQ_ASSERT_NOW(a_stall_only_on_hold, !scan_ready, result_valid && !result_ready,
        "scan_ready low without a stalled result")
    `PCQ_ASSERT_NEXT(a_result_follows_scan, scan_fire, result_valid,
        "no result after a scan transfer")
    `PCQ_ASSERT_NEXT(a_zero_sample_clears, scan_fire && (scan.rear_internal_sample == '0),
        !result.qualified_flags[pcq_pkg::CH_REAR_INT]
        && !result.qualified_flags[pcq_pkg::CH_REAR_INT_FAR],
        "rear internal flag set by a zero sample")
    `PCQ_ASSERT_NOW(a_mode_exclusive, result_valid && result.collision_rear_far,
        !result.collision_left && !result.collision_right,
        "hoop-up and hoop-down outputs active together")

endmodule

>>> tb/testbench.sv
// Testbench for the proximity collision qualifier: directed table plus random scans.
// Depends on pcq_pkg and the proximity_collision_qualifier top level.
// Results are checked against typed table values or a local debounce predictor.
`timescale 1ns / 1ps

module testbench;

    import pcq_pkg::*;

    localparam int         CYCLE_LIMIT = 200000;
    localparam cfg_index_t REG_UNUSED  = cfg_index_t'(7);

    typedef enum logic { ROW_SCAN, ROW_CFG } row_kind_e;

    typedef struct {
        row_kind_e  kind;
        cfg_index_t idx;
        cfg_data_t  data;
        scan_t      s;
        bit         typed;
        result_t    exp;
    } dir_row_t;

    logic       clk;
    logic       rst_n;
    logic       scan_valid;
    logic       scan_ready;
    scan_t      scan;
    logic       result_valid;
    logic       result_ready;
    result_t    result;
    logic       cfg_valid;
    logic       cfg_ready;
    cfg_index_t cfg_index;
    cfg_data_t  cfg_data;

    // Predictor state and its copy of the registers
    sample_t    limit_reg [NUM_CHANNELS];
    cnt_t       confirm_reg;
    cnt_t       hit_count [NUM_CHANNELS];
    flags_t     chan_flag;

    result_t    expected_results [$];
    dir_row_t   rows [$];
    int         mismatch_count = 0;
    int         cycle_count = 0;
    bit         steady_flow = 1'b0;
    bit         hoops_state = 1'b0;

    proximity_collision_qualifier u_top
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .scan_valid   (scan_valid),
        .scan_ready   (scan_ready),
        .scan         (scan),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Register write as the block sees it; index 7 is dropped
    function automatic void apply_reg(cfg_index_t idx, cfg_data_t data);
        if (int'(idx) < NUM_CHANNELS)
            limit_reg[idx] = sample_t'(data);
        else if (idx == REG_CONFIRM_COUNT)
            confirm_reg = cnt_t'(data);
    endfunction

    // Debounce update for one scan, then mode select of the outputs
    function automatic result_t predict_scan(scan_t s);
        sample_t smp [NUM_CHANNELS];
        result_t r;
        smp[CH_REAR_INT]     = s.rear_internal_sample;
        smp[CH_REAR_INT_FAR] = s.rear_internal_sample;
        smp[CH_REAR_HOOP]    = s.rear_hoop_sample;
        smp[CH_LEFT_HOOP]    = s.left_hoop_sample;
        smp[CH_RIGHT_HOOP]   = s.right_hoop_sample;
        smp[CH_FRONT]        = s.front_sample;
        for (int c = 0; c < NUM_CHANNELS; c++)
        begin
            if (smp[c] > limit_reg[c])
            begin
                if (hit_count[c] != CNT_MAX)
                    hit_count[c] = hit_count[c] + 1'b1;
                if (hit_count[c] >= confirm_reg)
                    chan_flag[c] = 1'b1;
            end
            else
            begin
                hit_count[c] = '0;
                chan_flag[c] = 1'b0;
            end
        end
        r.collision_rear     = s.hoops_down ? chan_flag[CH_REAR_HOOP] : chan_flag[CH_REAR_INT];
        r.collision_rear_far = s.hoops_down ? 1'b0 : chan_flag[CH_REAR_INT_FAR];
        r.collision_front    = chan_flag[CH_FRONT];
        r.collision_left     = s.hoops_down ? chan_flag[CH_LEFT_HOOP] : 1'b0;
        r.collision_right    = s.hoops_down ? chan_flag[CH_RIGHT_HOOP] : 1'b0;
        r.qualified_flags    = chan_flag;
        return r;
    endfunction

    function automatic void compare_result(result_t e, result_t g);
        if (g.collision_rear !== e.collision_rear)
        begin
            $error("collision_rear: expected %0d, got %0d", e.collision_rear, g.collision_rear);
            mismatch_count++;
        end
        if (g.collision_rear_far !== e.collision_rear_far)
        begin
            $error("collision_rear_far: expected %0d, got %0d",
                   e.collision_rear_far, g.collision_rear_far);
            mismatch_count++;
        end
        if (g.collision_front !== e.collision_front)
        begin
            $error("collision_front: expected %0d, got %0d",
                   e.collision_front, g.collision_front);
            mismatch_count++;
        end
        if (g.collision_left !== e.collision_left)
        begin
            $error("collision_left: expected %0d, got %0d", e.collision_left, g.collision_left);
            mismatch_count++;
        end
        if (g.collision_right !== e.collision_right)
        begin
            $error("collision_right: expected %0d, got %0d",
                   e.collision_right, g.collision_right);
            mismatch_count++;
        end
        if (g.qualified_flags !== e.qualified_flags)
        begin
            $error("qualified_flags: expected %h, got %h", e.qualified_flags, g.qualified_flags);
            mismatch_count++;
        end
    endfunction

    function automatic result_t mk_res(logic rear, logic far, logic front, logic left,
                                       logic right, flags_t flags);
        result_t r;
        r.collision_rear     = rear;
        r.collision_rear_far = far;
        r.collision_front    = front;
        r.collision_left     = left;
        r.collision_right    = right;
        r.qualified_flags    = flags;
        return r;
    endfunction

    function automatic scan_t mk_scan(int ri, int rh, int lh, int rr, int fr, logic hd);
        scan_t s;
        s.rear_internal_sample = sample_t'(ri);
        s.rear_hoop_sample     = sample_t'(rh);
        s.left_hoop_sample     = sample_t'(lh);
        s.right_hoop_sample    = sample_t'(rr);
        s.front_sample         = sample_t'(fr);
        s.hoops_down           = hd;
        return s;
    endfunction

    function automatic void add_scan(scan_t s, bit typed, result_t exp);
        dir_row_t r;
        r.kind  = ROW_SCAN;
        r.idx   = '0;
        r.data  = '0;
        r.s     = s;
        r.typed = typed;
        r.exp   = exp;
        rows.push_back(r);
    endfunction

    function automatic void add_cfg(cfg_index_t idx, int data);
        dir_row_t r;
        r.kind  = ROW_CFG;
        r.idx   = idx;
        r.data  = cfg_data_t'(data);
        r.s     = '0;
        r.typed = 1'b0;
        r.exp   = '0;
        rows.push_back(r);
    endfunction

    // Random sample, edges favored, on the asked side; a 1023 limit is not exceeded
    function automatic sample_t pick_sample(sample_t lim_v, bit above);
        int v;
        if (above && lim_v != LIMIT_RESET)
        begin
            if ($urandom_range(0, 3) == 0)
                v = int'(lim_v) + 1;
            else
                v = $urandom_range(int'(lim_v) + 1, 1023);
        end
        else
        begin
            if ($urandom_range(0, 3) == 0)
                v = int'(lim_v);
            else
                v = $urandom_range(0, int'(lim_v));
        end
        return sample_t'(v);
    endfunction

    // One scan transfer; valid stays high into the next scan when there is no gap
    task automatic send_scan(scan_t s, bit typed, result_t typed_exp);
        int      gap;
        result_t pred;
        gap = steady_flow ? 0 : $urandom_range(0, 6);
        if (gap > 0)
        begin
            scan_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        scan_valid <= 1'b1;
        scan       <= s;
        do @(negedge clk); while (!scan_ready);
        @(posedge clk);
        pred = predict_scan(s);
        expected_results.push_back(typed ? typed_exp : pred);
    endtask

    task automatic write_reg(cfg_index_t idx, cfg_data_t data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(negedge clk); while (!cfg_ready);
        @(posedge clk);
        apply_reg(idx, data);
    endtask

    // Let every pending result drain, with scan_valid held low
    task automatic drain();
        scan_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Random register settings, extremes included
    task automatic random_config();
        int pick;
        int conf;
        for (int i = 0; i < NUM_CHANNELS; i++)
        begin
            pick = $urandom_range(0, 9);
            case (pick)
                0:       write_reg(cfg_index_t'(i), cfg_data_t'(0));
                1:       write_reg(cfg_index_t'(i), cfg_data_t'(1023));
                2:       write_reg(cfg_index_t'(i), cfg_data_t'(1022));
                default: write_reg(cfg_index_t'(i), cfg_data_t'($urandom_range(0, 1023)));
            endcase
        end
        pick = $urandom_range(0, 5);
        case (pick)
            0:       conf = 0;
            1:       conf = 1;
            2:       conf = 2;
            3:       conf = 255;
            default: conf = $urandom_range(1, 8);
        endcase
        // upper data bits are don't-care for the confirm count
        write_reg(REG_CONFIRM_COUNT, cfg_data_t'(($urandom_range(0, 3) << 8) | conf));
        if ($urandom_range(0, 1) == 0)
            write_reg(REG_UNUSED, cfg_data_t'($urandom_range(0, 1023)));
        cfg_valid <= 1'b0;
    endtask

    // Runs of hits and misses per sensor, plus pure noise scans unless saturating
    task automatic run_phase(int n_scans, bit saturate);
        bit      above [5];
        scan_t   s;
        sample_t ri_lim;
        for (int k = 0; k < 5; k++)
            above[k] = saturate ? 1'b1 : 1'($urandom_range(0, 1));
        if (saturate)
            ri_lim = (limit_reg[CH_REAR_INT] > limit_reg[CH_REAR_INT_FAR]) ?
                     limit_reg[CH_REAR_INT] : limit_reg[CH_REAR_INT_FAR];
        else
            ri_lim = $urandom_range(0, 1) ? limit_reg[CH_REAR_INT] :
                                            limit_reg[CH_REAR_INT_FAR];
        for (int i = 0; i < n_scans; i++)
        begin
            if (i % 40 == 0)
                steady_flow = ($urandom_range(0, 3) == 0);
            if (saturate)
            begin
                if (i == n_scans - 20)
                    for (int k = 0; k < 5; k++)
                        above[k] = 1'b0;
            end
            else
            begin
                for (int k = 0; k < 5; k++)
                    if ($urandom_range(0, 9) == 0)
                        above[k] = !above[k];
                if ($urandom_range(0, 7) == 0)
                    hoops_state = !hoops_state;
            end
            if (!saturate && $urandom_range(0, 9) == 0)
            begin
                s = mk_scan($urandom_range(0, 1023), $urandom_range(0, 1023),
                            $urandom_range(0, 1023), $urandom_range(0, 1023),
                            $urandom_range(0, 1023), 1'($urandom_range(0, 1)));
            end
            else
            begin
                s.rear_internal_sample = pick_sample(ri_lim, above[0]);
                s.rear_hoop_sample     = pick_sample(limit_reg[CH_REAR_HOOP], above[1]);
                s.left_hoop_sample     = pick_sample(limit_reg[CH_LEFT_HOOP], above[2]);
                s.right_hoop_sample    = pick_sample(limit_reg[CH_RIGHT_HOOP], above[3]);
                s.front_sample         = pick_sample(limit_reg[CH_FRONT], above[4]);
                s.hoops_down           = hoops_state;
            end
            send_scan(s, 1'b0, '0);
        end
    endtask

    // Result receiver with random stalls
    initial
    begin
        int      gap;
        result_t got;
        result_ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            gap = steady_flow ? 0 : $urandom_range(0, 6);
            if (gap > 0)
            begin
                result_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            result_ready <= 1'b1;
            do @(negedge clk); while (!result_valid);
            got = result;
            if (expected_results.size() == 0)
            begin
                $error("result with no scan pending: %h", got);
                mismatch_count++;
            end
            else
                compare_result(expected_results.pop_front(), got);
            @(posedge clk);
        end
    end

    // Main sequence
    initial
    begin
        row_kind_e prev_kind;
        rst_n      <= 1'b0;
        scan_valid <= 1'b0;
        scan       <= '0;
        cfg_valid  <= 1'b0;
        cfg_index  <= '0;
        cfg_data   <= '0;
        for (int c = 0; c < NUM_CHANNELS; c++)
        begin
            limit_reg[c] = LIMIT_RESET;
            hit_count[c] = '0;
        end
        confirm_reg = CONFIRM_RESET;
        chan_flag   = '0;

        // Reset values: no sample can exceed an all-ones threshold
        add_scan(mk_scan(1023, 1023, 1023, 1023, 1023, 1'b0), 1'b1, mk_res(0, 0, 0, 0, 0, 6'h00));
        add_scan(mk_scan(0, 0, 0, 0, 0, 1'b1), 1'b1, mk_res(0, 0, 0, 0, 0, 6'h00));
        // Zero thresholds, confirm of one written with junk in the upper bits
        for (int i = 0; i < NUM_CHANNELS; i++)
            add_cfg(cfg_index_t'(i), 0);
        add_cfg(REG_CONFIRM_COUNT, 'h301);
        add_scan(mk_scan(1023, 1023, 1023, 1023, 1023, 1'b0), 1'b1, mk_res(1, 1, 1, 0, 0, 6'h3f));
        add_scan(mk_scan(1023, 1023, 1023, 1023, 1023, 1'b1), 1'b1, mk_res(1, 0, 1, 1, 1, 6'h3f));
        add_scan(mk_scan(0, 0, 0, 0, 0, 1'b1), 1'b1, mk_res(0, 0, 0, 0, 0, 6'h00));
        // Confirm count of zero: first hit sets the flag
        add_cfg(REG_CONFIRM_COUNT, 'h300);
        add_scan(mk_scan(1, 1, 1, 1, 1, 1'b0), 1'b1, mk_res(1, 1, 1, 0, 0, 6'h3f));
        // Confirm raised to its top while flags are set: flags hold
        add_cfg(REG_CONFIRM_COUNT, 'h2ff);
        add_scan(mk_scan(1023, 1023, 1023, 1023, 1023, 1'b1), 1'b1, mk_res(1, 0, 1, 1, 1, 6'h3f));
        add_scan(mk_scan(0, 0, 0, 0, 0, 1'b0), 1'b1, mk_res(0, 0, 0, 0, 0, 6'h00));
        add_scan(mk_scan(1, 1, 1, 1, 1, 1'b0), 1'b1, mk_res(0, 0, 0, 0, 0, 6'h00));
        // Unknown index is dropped; then thresholds at assorted points
        add_cfg(REG_UNUSED, 'h3ff);
        add_cfg(cfg_index_t'(CH_REAR_INT), 512);
        add_cfg(cfg_index_t'(CH_REAR_INT_FAR), 100);
        add_cfg(cfg_index_t'(CH_REAR_HOOP), 'h155);
        add_cfg(cfg_index_t'(CH_LEFT_HOOP), 'h2aa);
        add_cfg(cfg_index_t'(CH_RIGHT_HOOP), 1022);
        add_cfg(cfg_index_t'(CH_FRONT), 1);
        add_cfg(REG_CONFIRM_COUNT, 'h3ff);
        add_cfg(REG_CONFIRM_COUNT, 2);
        add_scan(mk_scan(513, 'h156, 'h2ab, 1023, 2, 1'b0), 1'b0, '0);
        add_scan(mk_scan(513, 'h156, 'h2ab, 1023, 2, 1'b0), 1'b0, '0);
        add_scan(mk_scan(512, 'h156, 'h2aa, 1023, 2, 1'b1), 1'b0, '0);
        add_scan(mk_scan(101, 'h155, 'h3ff, 0, 1, 1'b1), 1'b0, '0);
        add_scan(mk_scan(0, 'h3ff, 'h2ab, 1023, 'h3ff, 1'b0), 1'b0, '0);
        add_scan(mk_scan(0, 'h3ff, 'h2ab, 1023, 'h3ff, 1'b1), 1'b0, '0);
        add_scan(mk_scan('h2aa, 'h155, 'h3ff, 1023, 'h2aa, 1'b1), 1'b0, '0);

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table
        prev_kind = ROW_SCAN;
        foreach (rows[i])
        begin
            if (rows[i].kind == ROW_CFG)
            begin
                if (prev_kind == ROW_SCAN)
                    drain();
                write_reg(rows[i].idx, rows[i].data);
            end
            else
            begin
                if (prev_kind == ROW_CFG)
                    cfg_valid <= 1'b0;
                send_scan(rows[i].s, rows[i].typed, rows[i].exp);
            end
            prev_kind = rows[i].kind;
        end
        drain();

        // Long unbroken hit runs: counters reach the top and hold there
        for (int i = 0; i < NUM_CHANNELS; i++)
            write_reg(cfg_index_t'(i), cfg_data_t'($urandom_range(0, 200)));
        write_reg(REG_CONFIRM_COUNT, cfg_data_t'(255));
        cfg_valid <= 1'b0;
        run_phase(300, 1'b1);

        // Random settings, one batch of scans each
        for (int p = 0; p < 7; p++)
        begin
            drain();
            random_config();
            run_phase(100, 1'b0);
        end

        drain();
        repeat (10) @(posedge clk);
        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
